// ===== rtl/cda_pkg.sv =====
// Package for the calendar date advance block: field widths, month and year
// constants, the item and step structs, and the Gregorian leap-year function.
// Used by every module of the block and by its checker.
package cda_pkg;

    localparam int COUNT_BITS = 16;
    localparam int YEAR_BITS  = 14;
    localparam int SUM_BITS   = COUNT_BITS + 1;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(2000);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] LEN_28    = 5'd28;
    localparam logic [4:0] LEN_29    = 5'd29;
    localparam logic [4:0] LEN_30    = 5'd30;
    localparam logic [4:0] LEN_31    = 5'd31;

    localparam logic OP_SET     = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Reciprocal of 25 scaled by 2^20; exact for every year that fits YEAR_BITS.
    localparam int                DIV25_SHIFT = 20;
    localparam logic [15:0]       DIV25_MUL   = 16'd41944;
    localparam int                PROD_BITS   = YEAR_BITS + 16;

    typedef struct packed {
        logic                  op;
        logic [3:0]            new_month;
        logic [4:0]            new_day;
        logic [YEAR_BITS-1:0]  new_year;
        logic [COUNT_BITS-1:0] day_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]           cur_month;
        logic [4:0]           cur_day;
        logic [YEAR_BITS-1:0] cur_year;
        logic                 set_ok;
        logic                 year_overflow;
    } t_out_item;

    typedef struct packed {
        logic [3:0]            month;
        logic                  leap;
        logic [4:0]            day;
        logic [SUM_BITS-1:0]   count;
    } t_step_arg;

    typedef struct packed {
        logic                  exceed;
        logic [SUM_BITS-1:0]   rest;
        logic [4:0]            day_sum;
    } t_step_res;

    // Divisible by 4, except centuries that are not divisible by 400.
    // A year is a century when it is divisible by 4 and by 25, and a
    // multiple of 400 when it is divisible by 16 and by 25.
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic [PROD_BITS-1:0] prod;
        logic [YEAR_BITS-1:0] q;
        logic [YEAR_BITS-1:0] q25;
        logic                 div25;
        prod  = PROD_BITS'(y) * PROD_BITS'(DIV25_MUL);
        q     = YEAR_BITS'(prod >> DIV25_SHIFT);
        q25   = (q << 4) + (q << 3) + q;
        div25 = (q25 == y);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

endpackage

// ===== rtl/cda_month_unit.sv =====
// Shared month step unit: month length, day overflow compare and remainder.
// Depends on cda_pkg for the step structs and month constants.
module cda_month_unit (
    input  cda_pkg::t_step_arg i_arg,
    output cda_pkg::t_step_res o_res
);
    import cda_pkg::*;

    logic [4:0]          len;
    logic [SUM_BITS-1:0] sum;

    always_comb begin
        case (i_arg.month)
            MONTH_FEB: len = i_arg.leap ? LEN_29 : LEN_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
            default: len = LEN_31;
        endcase
    end

    // The remainder is only taken when the sum passes the month length, so it
    // never goes below one.
    assign sum             = i_arg.count + SUM_BITS'(i_arg.day);
    assign o_res.exceed    = sum > SUM_BITS'(len);
    assign o_res.rest      = sum - SUM_BITS'(len);
    assign o_res.day_sum   = sum[4:0];

endmodule

// ===== rtl/calendar_date_advance_top.sv =====
// Top level of the calendar date advance block: item sequencer, stored date,
// leap register and result register. Depends on cda_pkg and cda_month_unit.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   input   | in        | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//   output  | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// After acceptance a set item passes through the prepare, set and done
// states, and done loads its result into the output register. An advance
// item passes through prepare, one walk step per month walked, and done;
// the single month step unit, used once per cycle, walks one month per step.
// Reset is synchronous and active low; it loads the date 1/1/2000 and empties
// the output register. A stalled output holds the finished result, and the
// block keeps taking a new item meanwhile; only a second finished result
// waits until the register is free.
module calendar_date_advance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cda_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cda_pkg::t_out_item o_out_item
);
    import cda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SET,
        S_WALK,
        S_DONE
    } t_state;

    // Sequencer and stored date.
    t_state                r_state,     n_state;
    logic [3:0]            r_month,     n_month;
    logic [4:0]            r_day,       n_day;
    logic [YEAR_BITS-1:0]  r_year,      n_year;

    // Working registers of the walk and of the set check.
    logic                  r_op,        n_op;
    logic [3:0]            r_w_month,   n_w_month;
    logic [YEAR_BITS-1:0]  r_w_year,    n_w_year;
    logic [SUM_BITS-1:0]   r_w_count,   n_w_count;
    logic [4:0]            r_set_day,   n_set_day;
    logic                  r_leap;
    logic                  r_ok,        n_ok;
    logic                  r_ovf,       n_ovf;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item,  n_out_item;

    t_step_arg             step_arg;
    t_step_res             step_res;
    logic                  set_valid;

    // The month step unit is shared by the set check and by every walk step.
    // For a set it compares the new day against the new month's length. The
    // walk carries the stored day plus the day count as one running total,
    // which ends as the new day of month.
    always_comb begin
        step_arg.month = r_w_month;
        step_arg.leap  = r_leap;
        if (r_state == S_SET) begin
            step_arg.day   = r_set_day;
            step_arg.count = '0;
        end else begin
            step_arg.day   = '0;
            step_arg.count = r_w_count;
        end
    end

    cda_month_unit u_month_unit (
        .i_arg (step_arg),
        .o_res (step_res)
    );

    assign set_valid = (r_w_month != 4'd0) && (r_w_month <= MONTH_DEC)
                    && (r_set_day != 5'd0) && (r_w_year != '0)
                    && !step_res.exceed;

    always_comb begin
        n_state     = r_state;
        n_month     = r_month;
        n_day       = r_day;
        n_year      = r_year;
        n_op        = r_op;
        n_w_month   = r_w_month;
        n_w_year    = r_w_year;
        n_w_count   = r_w_count;
        n_set_day   = r_set_day;
        n_ok        = r_ok;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        // The consumer takes the waiting result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_item.op;
                    n_state = S_PREP;
                    if (i_in_item.op == OP_SET) begin
                        n_w_month = i_in_item.new_month;
                        n_set_day = i_in_item.new_day;
                        n_w_year  = i_in_item.new_year;
                    end else begin
                        n_w_month = r_month;
                        n_w_year  = r_year;
                        n_w_count = SUM_BITS'(i_in_item.day_count) + SUM_BITS'(r_day);
                    end
                end
            end
            // A state in which the leap flag follows the working year.
            S_PREP: begin
                n_state = (r_op == OP_SET) ? S_SET : S_WALK;
            end
            S_SET: begin
                n_ok    = set_valid;
                n_ovf   = 1'b0;
                n_state = S_DONE;
                if (set_valid) begin
                    n_month = r_w_month;
                    n_day   = r_set_day;
                    n_year  = r_w_year;
                end
            end
            // The year only changes into January, whose length does not need
            // the leap flag, so the flag has caught up before February.
            S_WALK: begin
                if (step_res.exceed) begin
                    n_w_count = step_res.rest;
                    if (r_w_month == MONTH_DEC) begin
                        if (r_w_year == YEAR_MAX) begin
                            n_month = MONTH_DEC;
                            n_day   = LEN_31;
                            n_year  = YEAR_MAX;
                            n_ok    = 1'b1;
                            n_ovf   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_w_year  = r_w_year + 1'b1;
                            n_w_month = MONTH_JAN;
                        end
                    end else begin
                        n_w_month = r_w_month + 1'b1;
                    end
                end else begin
                    n_month = r_w_month;
                    n_day   = step_res.day_sum;
                    n_year  = r_w_year;
                    n_ok    = 1'b1;
                    n_ovf   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.cur_month     = r_month;
                    n_out_item.cur_day       = r_day;
                    n_out_item.cur_year      = r_year;
                    n_out_item.set_ok        = r_ok;
                    n_out_item.year_overflow = r_ovf;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_month     <= MONTH_JAN;
            r_day       <= DAY_FIRST;
            r_year      <= YEAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_month     <= n_month;
            r_day       <= n_day;
            r_year      <= n_year;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_w_month  <= n_w_month;
        r_w_year   <= n_w_year;
        r_w_count  <= n_w_count;
        r_set_day  <= n_set_day;
        r_leap     <= is_leap(r_w_year);
        r_ok       <= n_ok;
        r_ovf      <= n_ovf;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/cda_checker.sv =====
// Port-level checker for the calendar date advance block, with its bind.
// Depends on cda_pkg for the item structs and the maximum year.
module cda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cda_pkg::t_out_item o_out_item
);
    import cda_pkg::*;

    // A held result must not change while the consumer stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // Every item passes through further states after acceptance, so the block is busy right after one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took no time for an item");

    // A saturated advance always ends on the last day of the maximum year.
    a_ovf_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.year_overflow |->
            o_out_item.set_ok && (o_out_item.cur_month == MONTH_DEC)
            && (o_out_item.cur_day == LEN_31) && (o_out_item.cur_year == YEAR_MAX))
        else $error("year overflow with a wrong date");

    // The stored date shown is always a plausible calendar date.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.cur_month != 4'd0) && (o_out_item.cur_month <= MONTH_DEC)
            && (o_out_item.cur_day != 5'd0) && (o_out_item.cur_year != '0))
        else $error("output date out of range");

endmodule

bind calendar_date_advance_top cda_checker u_cda_checker (.*);

// ===== tb/calendar_date_advance_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_advance_top: a table of directed items and
// random set/advance items, checked against a Gregorian date predictor in the bench.
// Depends on cda_pkg (item structs, op codes, year limit) and the block's RTL.
module calendar_date_advance_top_tb;
    import cda_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 82;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Date held by the predictor; it mirrors the block's stored date.
    int unsigned date_month;
    int unsigned date_day;
    int unsigned date_year;

    t_out_item     pending_dates[$];
    t_directed_row directed_rows[$];

    int mismatches;
    int results_seen;
    int items_sent;
    int sets_taken;
    int sets_refused;
    int advances;
    int saturations;
    int send_idle_pct;
    int recv_idle_pct;
    int stuck_cycles;

    calendar_date_advance_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic bit gregorian_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB) begin
            return gregorian_leap(y) ? 29 : 28;
        end
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic t_in_item set_item(input int unsigned m, input int unsigned d,
                                          input int unsigned y);
        t_in_item it;
        it = '0;
        it.op = OP_SET;
        it.new_month = 4'(m);
        it.new_day = 5'(d);
        it.new_year = YEAR_BITS'(y);
        return it;
    endfunction

    function automatic t_in_item advance_item(input int unsigned n);
        t_in_item it;
        it = '0;
        it.op = OP_ADVANCE;
        it.day_count = COUNT_BITS'(n);
        return it;
    endfunction

    function automatic t_out_item date_result(input int unsigned m, input int unsigned d,
                                              input int unsigned y, input bit ok,
                                              input bit ovf);
        t_out_item r;
        r.cur_month = 4'(m);
        r.cur_day = 5'(d);
        r.cur_year = YEAR_BITS'(y);
        r.set_ok = ok;
        r.year_overflow = ovf;
        return r;
    endfunction

    // Applies one item to the predicted date and returns the result it must produce.
    function automatic t_out_item next_date(input t_in_item it);
        int unsigned m;
        int unsigned d;
        int unsigned y;
        longint      n;
        bit          ok;
        bit          ovf;
        ok = 1'b1;
        ovf = 1'b0;
        if (it.op == OP_SET) begin
            m = it.new_month;
            d = it.new_day;
            y = it.new_year;
            if (m < 1 || m > 12 || d < 1 || y < 1 || d > days_in_month(m, y)) begin
                ok = 1'b0;
                sets_refused++;
            end else begin
                date_month = m;
                date_day = d;
                date_year = y;
                sets_taken++;
            end
        end else begin
            advances++;
            n = it.day_count;
            m = date_month;
            y = date_year;
            // Whole months are peeled off first; what is left lands in the final month.
            while (date_day + n > days_in_month(m, y)) begin
                n -= days_in_month(m, y);
                if (m == MONTH_DEC) begin
                    if (y >= YEAR_MAX) begin
                        ovf = 1'b1;
                        break;
                    end
                    y++;
                    m = MONTH_JAN;
                end else begin
                    m++;
                end
            end
            if (ovf) begin
                saturations++;
                date_month = MONTH_DEC;
                date_day = 31;
                date_year = YEAR_MAX;
            end else begin
                date_month = m;
                date_day = date_day + int'(n);
                date_year = y;
            end
        end
        return date_result(date_month, date_day, date_year, ok, ovf);
    endfunction

    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            return $urandom_range(YEAR_MAX, YEAR_MAX - 83);
        end else if (r < 25) begin
            return $urandom_range(10, 1);
        end else if (r < 35) begin
            return 100 * $urandom_range(163, 1);
        end
        return $urandom_range(YEAR_MAX, 1);
    endfunction

    // Mostly valid dates followed by advances; a share of arbitrary, mostly refused, sets.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned r;
        int unsigned m;
        int unsigned y;
        it.op = OP_SET;
        it.new_month = 4'($urandom);
        it.new_day = 5'($urandom);
        it.new_year = YEAR_BITS'($urandom);
        it.day_count = COUNT_BITS'($urandom);
        r = $urandom_range(99);
        if (r < 40) begin
            m = $urandom_range(12, 1);
            y = pick_year();
            it.new_month = 4'(m);
            it.new_year = YEAR_BITS'(y);
            if ($urandom_range(99) < 30) begin
                it.new_day = 5'(days_in_month(m, y));
            end else begin
                it.new_day = 5'($urandom_range(days_in_month(m, y), 1));
            end
        end else if (r >= 52) begin
            it.op = OP_ADVANCE;
            r = $urandom_range(99);
            if (r < 5) begin
                it.day_count = COUNT_BITS'($urandom_range(65535));
            end else if (r < 20) begin
                it.day_count = COUNT_BITS'($urandom_range(31));
            end else begin
                it.day_count = COUNT_BITS'($urandom_range(800));
            end
        end
        return it;
    endfunction

    task automatic add_row(input t_in_item it, input bit typed, input t_out_item want);
        t_directed_row row;
        row.item = it;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns, result %0d, %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_dates.size() == 0) begin
            report_mismatch("result with nothing pending, month", got.cur_month, 0);
        end else begin
            want = pending_dates.pop_front();
            if (got.cur_month !== want.cur_month)
                report_mismatch("cur_month", got.cur_month, want.cur_month);
            if (got.cur_day !== want.cur_day)
                report_mismatch("cur_day", got.cur_day, want.cur_day);
            if (got.cur_year !== want.cur_year)
                report_mismatch("cur_year", got.cur_year, want.cur_year);
            if (got.set_ok !== want.set_ok)
                report_mismatch("set_ok", got.set_ok, want.set_ok);
            if (got.year_overflow !== want.year_overflow)
                report_mismatch("year_overflow", got.year_overflow, want.year_overflow);
        end
        results_seen++;
    endtask

    // Called at a rising edge; returns at the edge that takes the item.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = next_date(it);
        pending_dates.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_for_results();
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    // Output side: check every taken result, then pick the next cycle's stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out_item);
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Long advances keep both channels quiet; the watchdog limit lies above the longest walk.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_out_item none;
        none = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        sets_taken = 0;
        sets_refused = 0;
        advances = 0;
        saturations = 0;
        stuck_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 75;
        date_month = MONTH_JAN;
        date_day = 1;
        date_year = 2000;

        // Refused sets, leap days, month and year roll-over, and saturation at the last year.
        add_row(advance_item(0), 1, date_result(1, 1, 2000, 1, 0));
        add_row(set_item(0, 1, 2000), 1, date_result(1, 1, 2000, 0, 0));
        add_row(set_item(13, 15, 2010), 1, date_result(1, 1, 2000, 0, 0));
        add_row(set_item(15, 31, YEAR_MAX), 1, date_result(1, 1, 2000, 0, 0));
        add_row(set_item(1, 1, 0), 1, date_result(1, 1, 2000, 0, 0));
        add_row(set_item(2, 29, 1900), 1, date_result(1, 1, 2000, 0, 0));
        add_row(set_item(2, 29, 2000), 1, date_result(2, 29, 2000, 1, 0));
        add_row(set_item(4, 31, 2001), 1, date_result(2, 29, 2000, 0, 0));
        add_row(set_item(6, 0, 2001), 1, date_result(2, 29, 2000, 0, 0));
        add_row(set_item(2, 28, 1900), 1, date_result(2, 28, 1900, 1, 0));
        add_row(advance_item(1), 0, none);
        add_row(set_item(2, 28, 2004), 1, date_result(2, 28, 2004, 1, 0));
        add_row(advance_item(1), 0, none);
        add_row(set_item(12, 31, 1999), 1, date_result(12, 31, 1999, 1, 0));
        add_row(advance_item(1), 0, none);
        add_row(set_item(1, 1, 1), 1, date_result(1, 1, 1, 1, 0));
        add_row(advance_item(65535), 0, none);
        add_row(set_item(12, 31, YEAR_MAX), 1, date_result(12, 31, YEAR_MAX, 1, 0));
        add_row(advance_item(0), 1, date_result(12, 31, YEAR_MAX, 1, 0));
        add_row(advance_item(1), 1, date_result(12, 31, YEAR_MAX, 1, 1));
        add_row(set_item(1, 1, YEAR_MAX), 1, date_result(1, 1, YEAR_MAX, 1, 0));
        add_row(advance_item(65535), 1, date_result(12, 31, YEAR_MAX, 1, 1));
        add_row(set_item(12, 1, YEAR_MAX), 1, date_result(12, 1, YEAR_MAX, 1, 0));
        add_row(advance_item(30), 0, none);
        add_row(set_item(2, 29, 2100), 1, date_result(12, 31, YEAR_MAX, 0, 0));
        add_row(set_item(2, 29, 2400), 1, date_result(2, 29, 2400, 1, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // Three idling patterns; the sender holds off until the block has drained
        // before each change, so no item is in flight across a phase boundary.
        for (int phase = 0; phase < 3; phase++) begin
            i_in_valid <= 1'b0;
            wait_for_results();
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 24 : 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_item(random_item(), 0, none);
            end
        end
        i_in_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_dates.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_dates.size());
        end
        $display("Ran %0d items: %0d sets taken, %0d sets refused, %0d advances",
                 items_sent, sets_taken, sets_refused, advances);
        $display("%0d advances saturated at the last year; %0d field mismatches",
                 saturations, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cda_pkg.sv
rtl/cda_month_unit.sv
rtl/calendar_date_advance_top.sv
rtl/cda_checker.sv
tb/calendar_date_advance_top_tb.sv
